@@ design/bia_pkg.sv @@
`timescale 1ns / 1ps
// Package for the bitmap identifier allocator: shared constants, item kinds,
// and the command/status structs between controller and datapath. No dependencies.
package bia_pkg;

  localparam int MAX_IDS_DEF   = 1024;
  localparam int ROW_WIDTH_DEF = 32;

  localparam int KIND_W      = 2;
  localparam int NUM_W       = 10;
  localparam int LOAD_W      = 32;
  localparam int CNT_IN_W    = 11;
  localparam int GRANT_W     = 10;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CNT_IN_W-1:0] ID_COUNT_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECLAIM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd2;

  typedef struct packed {
    logic start;
    logic issue;
    logic step;
    logic write;
    logic clear;
    logic out_load;
  } bia_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              early_fail;
    logic              hit;
    logic              last;
    logic              clr_last;
    logic              out_free;
  } bia_stat_t;

endpackage

@@ design/bia_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/bia_ctrl.sv @@
`timescale 1ns / 1ps
// Controller FSM of the bitmap identifier allocator: clear pass, dispatch,
// row scan, write-back and result hand-off. Depends on bia_pkg.
module bia_ctrl
  import bia_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  bia_stat_t stat,
  output bia_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PRIME = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        unique case (stat.kind)
          KIND_ALLOC, KIND_RECLAIM: begin
            if (stat.early_fail) begin
              state_nxt = ST_DONE;
            end else begin
              cmd.issue = 1'b1;
              state_nxt = ST_SCAN;
            end
          end
          KIND_LOAD: state_nxt = ST_WB;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        cmd.step  = 1'b1;
        if (stat.hit) begin
          state_nxt = ST_WB;
        end else if (stat.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_WB: begin
        cmd.write = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_tvalid) |=> (state_r == ST_PRIME))
    else $error("accepted word not dispatched");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.write, cmd.clear, cmd.out_load}))
    else $error("conflicting commands");

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> (state_r == ST_CLEAR))
    else $error("clear pass skipped after reset");

endmodule

@@ design/bia_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the bitmap identifier allocator: count register, bitmap RAM,
// scan counters, row evaluation, write-back and output register. Depends on bia_pkg, bia_ram.
module bia_dp
  import bia_pkg::*;
#(
  parameter int MAX_IDS   = MAX_IDS_DEF,
  parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [NUM_W-1:0]    in_num,
  input  logic [LOAD_W-1:0]   in_row,
  input  logic                cfg_valid,
  input  logic [CNT_IN_W-1:0] cfg_data,
  input  bia_cmd_t            cmd,
  output bia_stat_t           stat,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_success,
  output logic [GRANT_W-1:0]  out_grant
);

  localparam int ROWS = (MAX_IDS + ROW_WIDTH - 1) / ROW_WIDTH;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = $clog2(ROW_WIDTH);
  localparam int BW0  = $clog2(MAX_IDS + ROW_WIDTH + 1);
  localparam int BW   = (BW0 > CNT_IN_W) ? BW0 : CNT_IN_W;

  logic [CNT_IN_W-1:0]  id_count_r;
  logic [KIND_W-1:0]    kind_r;
  logic [BW-1:0]        num_r;
  logic [BW-1:0]        cnt_r;
  logic [BW-1:0]        base_r;
  logic [RW-1:0]        iss_r;
  logic [RW-1:0]        cur_r;
  logic [RW-1:0]        clr_r;
  logic [RW-1:0]        wb_addr_r;
  logic [ROW_WIDTH-1:0] wb_data_r;
  logic                 wb_en_r;
  logic                 res_ok_r;
  logic [GRANT_W-1:0]   res_grant_r;
  logic                 out_valid_r;
  logic                 out_success_r;
  logic [GRANT_W-1:0]   out_grant_r;

  logic [BW-1:0]        cnt_in;
  logic [BW-1:0]        cnt_eff;
  logic                 load_ok;
  logic [ROW_WIDTH-1:0] rd_data;
  logic [ROW_WIDTH-1:0] avail;
  logic [BW-1:0]        lim;
  logic [CW-1:0]        idx;
  logic [BW-1:0]        off;
  logic [CW-1:0]        col;
  logic                 in_row_hit;
  logic                 hit;
  logic                 ram_we;
  logic [RW-1:0]        ram_waddr;
  logic [ROW_WIDTH-1:0] ram_wdata;

  assign cnt_in  = BW'(id_count_r);
  assign cnt_eff = (cnt_in > BW'(MAX_IDS)) ? BW'(MAX_IDS) : cnt_in;
  assign load_ok = (in_kind == KIND_LOAD) && (BW'(in_num) < BW'(ROWS));

  // Free bits of the current row that lie below the count.
  assign lim = cnt_r - base_r;
  always_comb begin
    for (int j = 0; j < ROW_WIDTH; j++) begin
      avail[j] = !rd_data[j] && (BW'(j) < lim);
    end
  end

  always_comb begin
    idx = '0;
    for (int j = ROW_WIDTH - 1; j >= 0; j--) begin
      if (avail[j]) begin
        idx = CW'(j);
      end
    end
  end

  assign off        = num_r - base_r;
  assign col        = off[CW-1:0];
  assign in_row_hit = (off < BW'(ROW_WIDTH));
  assign hit        = (kind_r == KIND_ALLOC) ? (|avail) : in_row_hit;

  assign stat.kind       = kind_r;
  assign stat.early_fail = (kind_r == KIND_ALLOC) ? (cnt_r == '0) : (num_r >= cnt_r);
  assign stat.hit        = hit;
  assign stat.last       = ((base_r + BW'(ROW_WIDTH)) >= cnt_r);
  assign stat.clr_last   = (clr_r == RW'(ROWS - 1));
  assign stat.out_free   = !out_valid_r || out_tready;

  assign ram_we    = cmd.clear || (cmd.write && wb_en_r);
  assign ram_waddr = cmd.clear ? clr_r : wb_addr_r;
  assign ram_wdata = cmd.clear ? '0 : wb_data_r;

  bia_ram #(
    .WIDTH (ROW_WIDTH),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_count_r  <= ID_COUNT_RESET;
      clr_r       <= '0;
      wb_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        id_count_r <= cfg_data;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + RW'(1);
      end
      if (cmd.start) begin
        wb_en_r <= load_ok;
      end else if (cmd.step && hit) begin
        wb_en_r <= (kind_r == KIND_ALLOC) || rd_data[col];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r      <= in_kind;
      num_r       <= BW'(in_num);
      cnt_r       <= cnt_eff;
      base_r      <= '0;
      iss_r       <= '0;
      cur_r       <= '0;
      wb_addr_r   <= RW'(in_num);
      wb_data_r   <= ROW_WIDTH'(in_row);
      res_ok_r    <= load_ok;
      res_grant_r <= '0;
    end else begin
      if (cmd.issue && (iss_r != RW'(ROWS - 1))) begin
        iss_r <= iss_r + RW'(1);
      end
      if (cmd.step) begin
        if (hit) begin
          wb_addr_r <= cur_r;
          if (kind_r == KIND_ALLOC) begin
            wb_data_r   <= rd_data | (ROW_WIDTH'(1) << idx);
            res_ok_r    <= 1'b1;
            res_grant_r <= GRANT_W'(base_r + BW'(idx));
          end else begin
            wb_data_r <= rd_data & ~(ROW_WIDTH'(1) << col);
            res_ok_r  <= rd_data[col];
          end
        end else begin
          base_r <= base_r + BW'(ROW_WIDTH);
          cur_r  <= cur_r + RW'(1);
        end
      end
    end
    if (cmd.out_load) begin
      out_success_r <= res_ok_r;
      out_grant_r   <= res_grant_r;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_success = out_success_r;
  assign out_grant   = out_grant_r;

  a_grant_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && hit && kind_r == KIND_ALLOC) |-> ((base_r + BW'(idx)) < cnt_r))
    else $error("grant at or above id count");

  a_fail_zero_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_success_r) |-> (out_grant_r == '0))
    else $error("failed word carries a grant");

  a_wb_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !cmd.clear) |-> ({1'b0, wb_addr_r} < (RW + 1)'(ROWS)))
    else $error("write-back row out of range");

endmodule

@@ design/bitmap_id_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the bitmap identifier allocator: stream ports, field packing,
// controller and datapath. Depends on bia_pkg, bia_ctrl, bia_dp.
// Usage:
//   The in_ channel takes one word per operation: in_tuser is the kind
//   (allocate, reclaim, load row), in_tdata carries the identifier or row
//   index and the raw row bits. Every word gives exactly one out_ word:
//   out_tuser is the success flag, out_tdata the granted identifier.
//   The cfg_ channel writes the identifier count; it is always ready. The
//   user must write it only while no word is in flight; the block itself
//   does not enforce this. Allocate and reclaim run dispatch, a row scan,
//   write-back and result hand-off, reading the bitmap rows up to the hit
//   (at most ceil(count / ROW_WIDTH)), one row per cycle from the
//   single-read-port bitmap RAM; an allocate that finds no free bit skips
//   write-back. Load goes from dispatch to write-back; an unused kind, an
//   out-of-range reclaim or a zero count goes straight to hand-off. No new
//   word is taken until the last one has been handed to the output register.
//   Reset (rst_n low, synchronous) restores the count to 1024 and runs a
//   clearing pass over all ROWS rows (32 by default); in_tready is low until
//   it ends. While out_tready is low the result is held in the output
//   register; one more word may be taken and worked, then in_tready stays low.
module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int MAX_IDS   = MAX_IDS_DEF,
  parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // inode_number[9:0], row_bits[41:10], zero pad
  input  logic [KIND_W-1:0]      in_tuser,   // kind[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // granted_id[9:0], zero pad
  output logic [0:0]             out_tuser,  // success[0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_IN_W-1:0]    cfg_data
);

  bia_cmd_t           cmd;
  bia_stat_t          stat;
  logic               out_success;
  logic [GRANT_W-1:0] out_grant;

  assign cfg_ready = 1'b1;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bia_dp #(
    .MAX_IDS   (MAX_IDS),
    .ROW_WIDTH (ROW_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_tuser),
    .in_num      (in_tdata[NUM_W-1:0]),
    .in_row      (in_tdata[NUM_W +: LOAD_W]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_success (out_success),
    .out_grant   (out_grant)
  );

  assign out_tdata = OUT_TDATA_W'(out_grant);
  assign out_tuser = out_success;

endmodule
